[rtl/i2c_register_access_sequencer_assert.svh]
// Assertion macros used by the top module of the I2C register access sequencer.
`ifndef I2C_REGISTER_ACCESS_SEQUENCER_ASSERT_SVH
`define I2C_REGISTER_ACCESS_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define I2CRAS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cras assertion failed");

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define I2CRAS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cras assertion failed");

`endif

[rtl/i2cras_pkg.sv]
// Package with the types, codes and helper functions of the I2C register access sequencer.
`timescale 1ns / 1ps

package i2cras_pkg;

    // Buffer geometry; the field widths of the interface fix the depth.
    localparam int BUF_DEPTH = 32;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    // Operation codes of an input item.
    localparam logic [2:0] OP_START_READ  = 3'd0;
    localparam logic [2:0] OP_START_WRITE = 3'd1;
    localparam logic [2:0] OP_LOAD_BYTE   = 3'd2;
    localparam logic [2:0] OP_TX_READY    = 3'd3;
    localparam logic [2:0] OP_RX_BYTE     = 3'd4;
    localparam logic [2:0] OP_READ_BACK   = 3'd5;

    // Mode codes as reported in a result item.
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_ADDR_HI = 3'd1;
    localparam logic [2:0] MODE_ADDR_LO = 3'd2;
    localparam logic [2:0] MODE_TO_RX   = 3'd3;
    localparam logic [2:0] MODE_TX_DATA = 3'd4;
    localparam logic [2:0] MODE_RX_DATA = 3'd5;

    // Sequencer state, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_ADDR_HI = 6'b000010,
        ST_ADDR_LO = 6'b000100,
        ST_TO_RX   = 6'b001000,
        ST_TX_DATA = 6'b010000,
        ST_RX_DATA = 6'b100000
    } state_t;

    // One input item as held in the input register.
    typedef struct packed {
        logic [2:0]  operation;
        logic [6:0]  dev_address;
        logic [15:0] reg_address;
        logic [5:0]  byte_count;
        logic [7:0]  data;
        logic [4:0]  index;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [2:0] mode;
        logic       start_request;
        logic [6:0] slave_address;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       restart_request;
        logic       stop_request;
        logic       done_res;
        logic [7:0] read_data;
    } result_t;

    // Buffer control from the sequencer to the byte stores.
    typedef struct packed {
        logic              tx_we;
        logic [BUF_AW-1:0] tx_waddr;
        logic [7:0]        tx_wdata;
        logic [BUF_AW-1:0] tx_raddr;
        logic              rx_we;
        logic [BUF_AW-1:0] rx_waddr;
        logic [7:0]        rx_wdata;
        logic [BUF_AW-1:0] rx_raddr;
    } buf_ctrl_t;

    // Limit a requested byte count to the buffer depth.
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] count);
        logic [CNT_W-1:0] limit;
        limit = CNT_W'(BUF_DEPTH);
        return (count > limit) ? limit : count;
    endfunction

    // Encode the one-hot state as the reported mode.
    function automatic logic [2:0] mode_code(input state_t st);
        logic [2:0] code;
        unique case (st)
            ST_IDLE:    code = MODE_IDLE;
            ST_ADDR_HI: code = MODE_ADDR_HI;
            ST_ADDR_LO: code = MODE_ADDR_LO;
            ST_TO_RX:   code = MODE_TO_RX;
            ST_TX_DATA: code = MODE_TX_DATA;
            ST_RX_DATA: code = MODE_RX_DATA;
            default:    code = MODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

[rtl/i2c_register_access_sequencer.sv]
// Top level of the I2C register access sequencer: input register, step logic, result register.
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle while results are taken; the input register is refilled as its item moves on.
// A waiting result stalls only the input register; the input side stays open while it is empty.
// Reset clears the transaction state, both 32-byte stores and both valid flags at once.
// No clearing pass is needed, so items are taken as soon as reset is released.
`timescale 1ns / 1ps

module i2c_register_access_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [6:0]  dev_address,
    input  logic [15:0] reg_address,
    input  logic [5:0]  byte_count,
    input  logic [7:0]  data,
    input  logic [4:0]  index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  mode,
    output logic        start_request,
    output logic [6:0]  slave_address,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        restart_request,
    output logic        stop_request,
    output logic        done_res,
    output logic [7:0]  read_data
);
    import i2cras_pkg::*;

`include "i2c_register_access_sequencer_assert.svh"

    item_t     item_reg;
    logic      item_valid_reg;
    result_t   result_reg;
    logic      out_valid_reg;
    result_t   result_next;
    buf_ctrl_t buf_ctrl;
    logic [7:0] tx_rdata;
    logic [7:0] rx_rdata;
    logic      step;

    // An item moves on when the result register is free or being emptied.
    assign step     = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || step;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.operation   <= operation;
            item_reg.dev_address <= dev_address;
            item_reg.reg_address <= reg_address;
            item_reg.byte_count  <= byte_count;
            item_reg.data        <= data;
            item_reg.index       <= index;
        end
    end

    // Sequencer step and byte stores.
    i2cras_fsm u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .item     (item_reg),
        .tx_rdata (tx_rdata),
        .rx_rdata (rx_rdata),
        .buf_ctrl (buf_ctrl),
        .result   (result_next)
    );

    i2cras_buf u_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (buf_ctrl),
        .tx_rdata (tx_rdata),
        .rx_rdata (rx_rdata)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign mode            = result_reg.mode;
    assign start_request   = result_reg.start_request;
    assign slave_address   = result_reg.slave_address;
    assign tx_valid        = result_reg.tx_valid;
    assign tx_byte         = result_reg.tx_byte;
    assign restart_request = result_reg.restart_request;
    assign stop_request    = result_reg.stop_request;
    assign done_res        = result_reg.done_res;
    assign read_data       = result_reg.read_data;

    // A finished transaction always reports idle.
    `I2CRAS_ASSERT_IMP(a_done_idle, out_valid_reg && result_reg.done_res, result_reg.mode == MODE_IDLE)
    // A start always leaves the sequencer in the address-high phase.
    `I2CRAS_ASSERT_IMP(a_start_addr_hi, out_valid_reg && result_reg.start_request, result_reg.mode == MODE_ADDR_HI)
    // A repeated start always moves to receive.
    `I2CRAS_ASSERT_IMP(a_restart_rx, out_valid_reg && result_reg.restart_request, result_reg.mode == MODE_RX_DATA)
    // A byte to send and a stop never come from the same item.
    `I2CRAS_ASSERT_IMP(a_tx_stop_excl, out_valid_reg, !(result_reg.tx_valid && result_reg.stop_request))
    // Every item that leaves the input register shows up as a result.
    `I2CRAS_ASSERT_NXT(a_step_result, step, out_valid_reg)

endmodule

[rtl/i2cras_buf.sv]
// Transmit and receive byte stores of the I2C register access sequencer.
`timescale 1ns / 1ps

module i2cras_buf (
    input  logic                        clk,
    input  logic                        rst_n,
    input  i2cras_pkg::buf_ctrl_t       ctrl,
    output logic [7:0]                  tx_rdata,
    output logic [7:0]                  rx_rdata
);
    import i2cras_pkg::*;

    logic [7:0] tx_store_reg [BUF_DEPTH];
    logic [7:0] rx_store_reg [BUF_DEPTH];

    // Transmit store: loaded by write-byte items, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUF_DEPTH; i++)
            begin
                tx_store_reg[i] <= '0;
            end
        end
        else if (ctrl.tx_we)
        begin
            tx_store_reg[ctrl.tx_waddr] <= ctrl.tx_wdata;
        end
    end

    // Receive store: filled by bytes from the bus, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUF_DEPTH; i++)
            begin
                rx_store_reg[i] <= '0;
            end
        end
        else if (ctrl.rx_we)
        begin
            rx_store_reg[ctrl.rx_waddr] <= ctrl.rx_wdata;
        end
    end

    // Each store is read at a single address.
    assign tx_rdata = tx_store_reg[ctrl.tx_raddr];
    assign rx_rdata = rx_store_reg[ctrl.rx_raddr];

endmodule

[rtl/i2cras_fsm.sv]
// Transaction state and per-item step logic of the I2C register access sequencer.
`timescale 1ns / 1ps

module i2cras_fsm (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  i2cras_pkg::item_t       item,
    input  logic [7:0]              tx_rdata,
    input  logic [7:0]              rx_rdata,
    output i2cras_pkg::buf_ctrl_t   buf_ctrl,
    output i2cras_pkg::result_t     result
);
    import i2cras_pkg::*;

    state_t            state_reg,   state_next;
    logic [15:0]       reg_addr_reg, reg_addr_next;
    logic [CNT_W-1:0]  rx_rem_reg,  rx_rem_next;
    logic [CNT_W-1:0]  tx_rem_reg,  tx_rem_next;
    logic [BUF_AW-1:0] rx_pos_reg,  rx_pos_next;
    logic [BUF_AW-1:0] tx_pos_reg,  tx_pos_next;
    logic [CNT_W-1:0]  rx_rem_after;

    // Step logic for the item in the input register.
    always_comb
    begin
        state_next    = state_reg;
        reg_addr_next = reg_addr_reg;
        rx_rem_next   = rx_rem_reg;
        tx_rem_next   = tx_rem_reg;
        rx_pos_next   = rx_pos_reg;
        tx_pos_next   = tx_pos_reg;
        rx_rem_after  = rx_rem_reg;
        result        = '0;

        buf_ctrl          = '0;
        buf_ctrl.tx_waddr = item.index;
        buf_ctrl.tx_wdata = item.data;
        buf_ctrl.tx_raddr = tx_pos_reg;
        buf_ctrl.rx_waddr = rx_pos_reg;
        buf_ctrl.rx_wdata = item.data;
        buf_ctrl.rx_raddr = item.index;

        unique case (item.operation)
            OP_START_READ, OP_START_WRITE:
            begin
                // A start abandons any running transaction.
                state_next    = ST_ADDR_HI;
                reg_addr_next = item.reg_address;
                if (item.operation == OP_START_READ)
                begin
                    rx_rem_next = clamp_count(item.byte_count);
                    tx_rem_next = '0;
                end
                else
                begin
                    tx_rem_next = clamp_count(item.byte_count);
                    rx_rem_next = '0;
                end
                rx_pos_next          = '0;
                tx_pos_next          = '0;
                result.start_request = 1'b1;
                result.slave_address = item.dev_address;
            end
            OP_LOAD_BYTE:
            begin
                // The store is written only as the item moves on.
                buf_ctrl.tx_we = step;
            end
            OP_TX_READY:
            begin
                unique case (state_reg)
                    ST_ADDR_HI:
                    begin
                        result.tx_valid = 1'b1;
                        result.tx_byte  = reg_addr_reg[15:8];
                        state_next      = ST_ADDR_LO;
                    end
                    ST_ADDR_LO:
                    begin
                        result.tx_valid = 1'b1;
                        result.tx_byte  = reg_addr_reg[7:0];
                        state_next      = (rx_rem_reg != '0) ? ST_TO_RX : ST_TX_DATA;
                    end
                    ST_TO_RX:
                    begin
                        result.restart_request = 1'b1;
                        result.stop_request    = (rx_rem_reg == CNT_W'(1));
                        state_next             = ST_RX_DATA;
                    end
                    ST_TX_DATA:
                    begin
                        // Position plus remaining never exceeds the depth.
                        if (tx_rem_reg != '0)
                        begin
                            result.tx_valid = 1'b1;
                            result.tx_byte  = tx_rdata;
                            tx_pos_next     = tx_pos_reg + BUF_AW'(1);
                            tx_rem_next     = tx_rem_reg - CNT_W'(1);
                        end
                        else
                        begin
                            result.stop_request = 1'b1;
                            result.done_res     = 1'b1;
                            state_next          = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        // Idle or receiving: the event is ignored.
                    end
                endcase
            end
            OP_RX_BYTE:
            begin
                if (state_reg == ST_RX_DATA)
                begin
                    if (rx_rem_reg != '0)
                    begin
                        buf_ctrl.rx_we = step;
                        rx_pos_next    = rx_pos_reg + BUF_AW'(1);
                        rx_rem_after   = rx_rem_reg - CNT_W'(1);
                    end
                    rx_rem_next = rx_rem_after;
                    if (rx_rem_after == CNT_W'(1))
                    begin
                        result.stop_request = 1'b1;
                    end
                    else if (rx_rem_after == '0)
                    begin
                        result.done_res = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end
            OP_READ_BACK:
            begin
                result.read_data = rx_rdata;
            end
            default:
            begin
                // Unused codes leave everything unchanged.
            end
        endcase

        result.mode = mode_code(state_next);
    end

    // Transaction state, updated as each item passes to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            reg_addr_reg <= '0;
            rx_rem_reg   <= '0;
            tx_rem_reg   <= '0;
            rx_pos_reg   <= '0;
            tx_pos_reg   <= '0;
        end
        else if (step)
        begin
            state_reg    <= state_next;
            reg_addr_reg <= reg_addr_next;
            rx_rem_reg   <= rx_rem_next;
            tx_rem_reg   <= tx_rem_next;
            rx_pos_reg   <= rx_pos_next;
            tx_pos_reg   <= tx_pos_next;
        end
    end

endmodule

[tb/testbench.sv]
// Self-checking testbench for the I2C register access sequencer: directed and random items.
`timescale 1ns / 1ps

module testbench;
    import i2cras_pkg::*;

    // Operation codes that the block does not use; it must ignore them.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int MAX_GAP        = 20;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int DRAIN_CYCLES   = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  operation = '0;
    logic [6:0]  dev_address = '0;
    logic [15:0] reg_address = '0;
    logic [5:0]  byte_count = '0;
    logic [7:0]  data = '0;
    logic [4:0]  index = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  mode;
    logic        start_request;
    logic [6:0]  slave_address;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        restart_request;
    logic        stop_request;
    logic        done_res;
    logic [7:0]  read_data;

    // Items waiting to be offered, and results predicted for accepted items.
    item_t   bus_events[$];
    result_t predicted_results[$];
    int      queued_total = 0;
    int      mismatch_count = 0;
    int      quiet_cycles = 0;

    // Driver pacing and the receiver's stall pattern.
    int          gap_left = 0;
    int          burst_left = 0;
    item_t       offered_item;
    logic        long_hold_req = 1'b0;
    int          hold_count = 0;
    logic [15:0] rx_cycle = '0;
    logic        ready_next;

    // Own copy of the sequencer state.
    logic [2:0]  seq_mode = MODE_IDLE;
    logic [15:0] seq_reg_addr = '0;
    logic [5:0]  rx_left = '0;
    logic [5:0]  tx_left = '0;
    logic [5:0]  rx_pos = '0;
    logic [5:0]  tx_pos = '0;
    logic [7:0]  rx_bytes [BUF_DEPTH];
    logic [7:0]  tx_bytes [BUF_DEPTH];

    // Checker scratch.
    item_t   taken_item;
    result_t want;
    result_t got;
    result_t fresh;

    i2c_register_access_sequencer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .dev_address     (dev_address),
        .reg_address     (reg_address),
        .byte_count      (byte_count),
        .data            (data),
        .index           (index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .mode            (mode),
        .start_request   (start_request),
        .slave_address   (slave_address),
        .tx_valid        (tx_valid),
        .tx_byte         (tx_byte),
        .restart_request (restart_request),
        .stop_request    (stop_request),
        .done_res        (done_res),
        .read_data       (read_data)
    );

    always #6 clk = ~clk;

    // Advance the predicted sequencer by one item and give the result it should report.
    task automatic advance_sequencer(input item_t it, output result_t res);
        logic [5:0] count;
        count = (it.byte_count > 6'(BUF_DEPTH)) ? 6'(BUF_DEPTH) : it.byte_count;
        res = '0;
        case (it.operation)
            OP_START_READ, OP_START_WRITE:
            begin
                // A start abandons whatever transaction was running.
                seq_mode = MODE_ADDR_HI;
                seq_reg_addr = it.reg_address;
                rx_left = (it.operation == OP_START_READ) ? count : 6'd0;
                tx_left = (it.operation == OP_START_WRITE) ? count : 6'd0;
                rx_pos = '0;
                tx_pos = '0;
                res.start_request = 1'b1;
                res.slave_address = it.dev_address;
            end
            OP_LOAD_BYTE:
                tx_bytes[it.index] = it.data;
            OP_TX_READY:
            begin
                case (seq_mode)
                    MODE_ADDR_HI:
                    begin
                        res.tx_valid = 1'b1;
                        res.tx_byte = seq_reg_addr[15:8];
                        seq_mode = MODE_ADDR_LO;
                    end
                    MODE_ADDR_LO:
                    begin
                        res.tx_valid = 1'b1;
                        res.tx_byte = seq_reg_addr[7:0];
                        seq_mode = (rx_left != 0) ? MODE_TO_RX : MODE_TX_DATA;
                    end
                    MODE_TO_RX:
                    begin
                        res.restart_request = 1'b1;
                        res.stop_request = (rx_left == 6'd1);
                        seq_mode = MODE_RX_DATA;
                    end
                    MODE_TX_DATA:
                    begin
                        if (tx_left != 0 && tx_pos < BUF_DEPTH)
                        begin
                            res.tx_valid = 1'b1;
                            res.tx_byte = tx_bytes[tx_pos[4:0]];
                            tx_pos = tx_pos + 6'd1;
                            tx_left = tx_left - 6'd1;
                        end
                        else
                        begin
                            res.stop_request = 1'b1;
                            res.done_res = 1'b1;
                            seq_mode = MODE_IDLE;
                        end
                    end
                    default:
                        ;
                endcase
            end
            OP_RX_BYTE:
            begin
                if (seq_mode == MODE_RX_DATA)
                begin
                    if (rx_left != 0 && rx_pos < BUF_DEPTH)
                    begin
                        rx_bytes[rx_pos[4:0]] = it.data;
                        rx_pos = rx_pos + 6'd1;
                        rx_left = rx_left - 6'd1;
                    end
                    // Stop is asked for ahead of the last byte.
                    if (rx_left == 6'd1)
                        res.stop_request = 1'b1;
                    else if (rx_left == 6'd0)
                    begin
                        seq_mode = MODE_IDLE;
                        res.done_res = 1'b1;
                    end
                end
            end
            OP_READ_BACK:
                res.read_data = rx_bytes[it.index];
            default:
                ;
        endcase
        res.mode = seq_mode;
    endtask

    task automatic check_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch on %s: expected %0d, got %0d", field, want_v, got_v);
        end
    endtask

    // An item of the given operation with every other field random.
    function automatic item_t random_item(input logic [2:0] op);
        item_t it;
        it.operation = op;
        it.dev_address = 7'($urandom);
        it.reg_address = 16'($urandom);
        it.byte_count = 6'($urandom);
        it.data = 8'($urandom);
        it.index = 5'($urandom);
        return it;
    endfunction

    // Mostly short transfers; now and then a large or over-long count.
    function automatic logic [5:0] pick_count();
        if ($urandom_range(0, 19) == 0)
            return ($urandom_range(0, 3) == 0) ? 6'(BUF_DEPTH) : 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, 6));
    endfunction

    task automatic queue_item(input item_t it);
        bus_events.push_back(it);
        queued_total++;
    endtask

    // A register transaction: start, then its transmit and receive events, maybe cut short.
    task automatic queue_transaction(input logic [2:0] start_op, input bit broken);
        item_t it;
        int    count;
        int    events;
        it = random_item(start_op);
        it.byte_count = pick_count();
        count = (it.byte_count > BUF_DEPTH) ? BUF_DEPTH : int'(it.byte_count);
        if (start_op == OP_START_WRITE)
            repeat ($urandom_range(0, 4)) queue_item(random_item(OP_LOAD_BYTE));
        queue_item(it);
        // Address high and low, then write data and the stop, or a read's restart and data.
        events = 3 + count;
        if (broken)
            events = $urandom_range(0, events - 1);
        for (int k = 0; k < events; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                queue_item(random_item($urandom_range(0, 1) ? OP_LOAD_BYTE : OP_READ_BACK));
            if (start_op == OP_START_READ && k >= 3)
                queue_item(random_item(OP_RX_BYTE));
            else
                queue_item(random_item(OP_TX_READY));
        end
        if (start_op == OP_START_READ)
            repeat ($urandom_range(0, 3)) queue_item(random_item(OP_READ_BACK));
    endtask

    task automatic queue_random(input int target);
        int stop_at;
        int pick;
        stop_at = queued_total + target;
        while (queued_total < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                queue_transaction(OP_START_WRITE, pick < 5);
            else if (pick < 85)
                queue_transaction(OP_START_READ, pick < 50);
            else
                repeat ($urandom_range(1, 4)) queue_item(random_item(3'($urandom_range(0, 7))));
        end
    endtask

    task automatic queue_directed();
        item_t it;
        // Read back before anything was received, and events that idle must ignore.
        it = random_item(OP_READ_BACK);
        it.index = 5'd31;
        queue_item(it);
        queue_item(random_item(OP_TX_READY));
        queue_item(random_item(OP_RX_BYTE));
        queue_item(random_item(OP_SPARE_6));
        queue_item(random_item(OP_SPARE_7));
        // Loads at both ends of the buffer.
        it = random_item(OP_LOAD_BYTE);
        it.index = 5'd0;
        it.data = 8'hFF;
        queue_item(it);
        it = random_item(OP_LOAD_BYTE);
        it.index = 5'd31;
        it.data = 8'h00;
        queue_item(it);
        // Two-byte write at the top address: high, low, two data bytes, stop.
        it = random_item(OP_START_WRITE);
        it.dev_address = 7'h7F;
        it.reg_address = 16'hFFFF;
        it.byte_count = 6'd2;
        queue_item(it);
        repeat (5) queue_item(random_item(OP_TX_READY));
        // A read of zero bytes turns into an empty write after the address.
        it = random_item(OP_START_READ);
        it.dev_address = '0;
        it.reg_address = '0;
        it.byte_count = '0;
        queue_item(it);
        repeat (3) queue_item(random_item(OP_TX_READY));
        // Single-byte read: the stop comes with the repeated start.
        it = random_item(OP_START_READ);
        it.byte_count = 6'd1;
        queue_item(it);
        repeat (3) queue_item(random_item(OP_TX_READY));
        it = random_item(OP_RX_BYTE);
        it.data = 8'hFF;
        queue_item(it);
        it = random_item(OP_READ_BACK);
        it.index = 5'd0;
        queue_item(it);
        // Over-long count, then a new start while the address is still pending.
        it = random_item(OP_START_READ);
        it.byte_count = 6'd63;
        queue_item(it);
        it = random_item(OP_START_WRITE);
        it.byte_count = '0;
        queue_item(it);
    endtask

    task automatic wait_drained();
        while (bus_events.size() != 0 || in_valid || predicted_results.size() != 0)
            @(posedge clk);
    endtask

    // Driver: bursts of items separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (bus_events.size() != 0)
            begin
                offered_item = bus_events.pop_front();
                operation <= offered_item.operation;
                dev_address <= offered_item.dev_address;
                reg_address <= offered_item.reg_address;
                byte_count <= offered_item.byte_count;
                data <= offered_item.data;
                index <= offered_item.index;
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stall pattern picked by bits 9:8 of a free-running counter, plus one long hold on request.
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 16'd1;
        if (long_hold_req && hold_count < LONG_HOLD)
        begin
            hold_count <= hold_count + 1;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_cycle[9:8])
                2'd0: ready_next = 1'b1;
                2'd1: ready_next = 1'($urandom_range(0, 1));
                2'd2: ready_next = (rx_cycle[1:0] == 2'd0);
                default: ready_next = ($urandom_range(0, 9) != 0);
            endcase
            out_ready <= ready_next;
        end
    end

    // Monitor: check each result against the oldest prediction, then predict for new items.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {mode, start_request, slave_address, tx_valid, tx_byte,
                       restart_request, stop_request, done_res, read_data};
                if (predicted_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result item with no item outstanding: %h", got);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("mode", want.mode, got.mode);
                    check_field("start_request", want.start_request, got.start_request);
                    check_field("slave_address", want.slave_address, got.slave_address);
                    check_field("tx_valid", want.tx_valid, got.tx_valid);
                    check_field("tx_byte", want.tx_byte, got.tx_byte);
                    check_field("restart_request", want.restart_request, got.restart_request);
                    check_field("stop_request", want.stop_request, got.stop_request);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("read_data", want.read_data, got.read_data);
                end
            end
            if (in_valid && in_ready)
            begin
                taken_item = {operation, dev_address, reg_address, byte_count, data, index};
                advance_sequencer(taken_item, fresh);
                predicted_results.push_back(fresh);
            end
        end
    end

    // Watchdog: too long without any item moving on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Stimulus sequence and end of run.
    initial
    begin
        for (int k = 0; k < BUF_DEPTH; k++)
        begin
            rx_bytes[k] = '0;
            tx_bytes[k] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        queue_directed();
        wait_drained();
        queue_random(RANDOM_ITEMS / 2);
        wait_drained();
        // The receiver holds off while the second half streams in.
        long_hold_req <= 1'b1;
        queue_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatch_count += predicted_results.size();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
